>>> design/lhs_pkg.sv
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared types and constants of the lane histogram steering block: counter
// widths, result field widths, steering codes and the scan control bundle.
// ----------------------------------------------------------------------------
package lhs_pkg;

	// Column histogram counters saturate at their all-ones value.
	localparam int unsigned CNT_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Frame total counter, saturating.
	localparam int unsigned TOTAL_W = 17;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Configuration data width (widest register).
	localparam int unsigned CFG_W = 17;
	localparam int unsigned CFG_IDX_W = 3;

	// Result field widths.
	localparam int unsigned POS_OUT_W = 9;
	localparam int unsigned OFF_W = 10;
	localparam int unsigned WIN_W = 9;

	// Offset saturation limits.
	localparam int OFF_MAX = 511;
	localparam int OFF_MIN = -512;

	// Steering codes.
	typedef logic [2:0] steer_code_t;
	localparam steer_code_t STEER_FWD = 3'd0;
	localparam steer_code_t STEER_R1 = 3'd1;
	localparam steer_code_t STEER_R2 = 3'd2;
	localparam steer_code_t STEER_R3 = 3'd3;
	localparam steer_code_t STEER_L1 = 3'd4;
	localparam steer_code_t STEER_L2 = 3'd5;
	localparam steer_code_t STEER_L3 = 3'd6;
	localparam steer_code_t STEER_HOLD = 3'd7;

	// Control from the sequencer to the peak search unit.
	typedef struct packed {
		logic start;      // new frame evaluation: reset both peak positions
		logic cmp_vld;    // read data of the scan pipeline is valid
		logic right;      // scan runs over the right window
		logic phase_end;  // last compare of the current pass
	} scan_ctl_t;

endpackage

>>> design/lhs_col_mem.sv
// ----------------------------------------------------------------------------
// lhs_col_mem
// Column histogram storage: one write port and one read port with a
// registered read. Contents are undefined after reset and are cleared by the
// sequencer.
// ----------------------------------------------------------------------------
module lhs_col_mem
	import lhs_pkg::*;
#(
	parameter int unsigned DEPTH = 400,
	parameter int unsigned AW = 9
) (
	input  logic             clk,
	input  logic [AW-1:0]    rd_addr,
	output logic [CNT_W-1:0] rd_data_q,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [CNT_W-1:0] wr_data
);

	logic [CNT_W-1:0] mem [DEPTH];

	// Write first in the code order; the read still returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

>>> design/lhs_peak_scan.sv
// ----------------------------------------------------------------------------
// lhs_peak_scan
// Shared count comparator for the peak search. The sequencer streams the
// column counts through it twice, once for the left window and once for the
// right window; the first column holding the largest count wins.
// ----------------------------------------------------------------------------
module lhs_peak_scan
	import lhs_pkg::*;
#(
	parameter int unsigned FRAME_WIDTH = 400,
	parameter int unsigned AW = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  logic [AW-1:0]    idx_s1,
	input  logic [CNT_W-1:0] cnt,
	input  logic [WIN_W-1:0] left_window_end,
	input  logic [WIN_W-1:0] right_window_start,
	output logic [AW-1:0]    left_q,
	output logic [AW-1:0]    right_q
);

	localparam int unsigned XW = (AW > WIN_W) ? AW : WIN_W;

	logic [CNT_W-1:0] best_q;
	logic             have_q;
	logic [XW-1:0]    idx_ext;
	logic             in_win;
	logic             take;

	// Window membership and the single count compare.
	assign idx_ext = XW'(idx_s1);
	assign in_win = ctl.right ? (idx_ext >= XW'(right_window_start))
	                          : (idx_ext < XW'(left_window_end));
	assign take = ctl.cmp_vld && in_win && (!have_q || (cnt > best_q));

	// Best count so far; cleared between the two passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.start || ctl.phase_end) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= cnt;
		end
	end

	// Peak positions; an empty window keeps the default position.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			left_q <= '0;
			right_q <= AW'(FRAME_WIDTH - 1);
		end else if (take) begin
			if (ctl.right) begin
				right_q <= idx_s1;
			end else begin
				left_q <= idx_s1;
			end
		end
	end

endmodule

>>> design/lhs_steer.sv
// ----------------------------------------------------------------------------
// lhs_steer
// Lane center, offset and steering code. The center is registered on load;
// the offset and code follow from the registered center.
// ----------------------------------------------------------------------------
module lhs_steer
	import lhs_pkg::*;
#(
	parameter int unsigned AW = 9
) (
	input  logic                    clk,
	input  logic                    load,
	input  logic [AW-1:0]           left_pos,
	input  logic [AW-1:0]           right_pos,
	input  logic [WIN_W-1:0]        frame_center,
	input  logic [WIN_W-1:0]        band_small,
	input  logic [WIN_W-1:0]        band_large,
	input  logic                    lane_end,
	input  steer_code_t             last_code,
	output logic [AW-1:0]           center_q,
	output logic signed [OFF_W-1:0] offset,
	output steer_code_t             code
);

	localparam int unsigned DW = AW + 2;
	localparam int unsigned FW = ((AW > WIN_W) ? AW : WIN_W) + 2;
	localparam int unsigned BW = WIN_W + 2;

	logic signed [DW-1:0]    diff;
	logic signed [DW-1:0]    diff_adj;
	logic signed [DW-1:0]    half;
	logic signed [FW-1:0]    off_full;
	logic signed [BW-1:0]    r;
	logic signed [BW-1:0]    bs;
	logic signed [BW-1:0]    bl;

	// Half of the distance, truncated toward zero.
	assign diff = $signed(DW'(right_pos)) - $signed(DW'(left_pos));
	assign diff_adj = diff + DW'(diff[DW-1]);
	assign half = diff_adj >>> 1;

	always_ff @(posedge clk) begin
		if (load) begin
			center_q <= left_pos + half[AW-1:0];
		end
	end

	// Offset from the reference column, saturated to the field range.
	assign off_full = $signed(FW'(center_q)) - $signed(FW'(frame_center));

	always_comb begin
		if (off_full > FW'(OFF_MAX)) begin
			offset = OFF_W'(OFF_MAX);
		end else if (off_full < $signed(FW'(OFF_MIN))) begin
			offset = OFF_W'(OFF_MIN);
		end else begin
			offset = off_full[OFF_W-1:0];
		end
	end

	// Steering bands, tested in priority order.
	assign r = BW'(offset);
	assign bs = $signed(BW'(band_small));
	assign bl = $signed(BW'(band_large));

	always_comb begin
		if (r == '0) begin
			code = STEER_FWD;
		end else if (r > 0 && r < bs) begin
			code = STEER_R1;
		end else if (r >= bs && r < bl) begin
			code = STEER_R2;
		end else if (r > bl) begin
			code = STEER_R3;
		end else if (r < 0 && r > -bs) begin
			code = STEER_L1;
		end else if (r <= -bs && r > -bl) begin
			code = STEER_L2;
		end else if (r < -bl) begin
			code = STEER_L3;
		end else if (lane_end) begin
			code = STEER_HOLD;
		end else begin
			code = last_code;
		end
	end

endmodule

>>> design/lane_histogram_steering.sv
// ----------------------------------------------------------------------------
// lane_histogram_steering
// Column histogram of a binary lane mask with peak search and steering code.
//
//   Channel  Signals                                         Direction
//   pixel    in_valid/in_ready, column, row, pixel_on,       in
//            frame_last
//   result   out_valid/out_ready, left_position,             out
//            right_position, lane_center, offset,
//            steering_code, lane_end
//   config   cfg_we, cfg_index, cfg_data                     in, write only
//
// An ordinary pixel is one read-modify-write of the single column memory;
// no new pixel is taken until it is done. The last pixel of a frame adds
// two passes of the shared comparator over the memory (the second pass also
// clears it), a center state and a result state.
// After reset a clearing pass over the column memory runs before the first
// pixel is taken; configuration writes are taken throughout.
// A stalled result waits in the output register while pixels keep flowing;
// only the next frame's result waits for it to leave.
// ----------------------------------------------------------------------------
module lane_histogram_steering
	import lhs_pkg::*;
#(
	parameter int unsigned FRAME_WIDTH = 400,
	parameter int unsigned FRAME_HEIGHT = 240
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [8:0]              column,
	input  logic [7:0]              row,
	input  logic                    pixel_on,
	input  logic                    frame_last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [POS_OUT_W-1:0]    left_position,
	output logic [POS_OUT_W-1:0]    right_position,
	output logic [POS_OUT_W-1:0]    lane_center,
	output logic signed [OFF_W-1:0] offset,
	output logic [2:0]              steering_code,
	output logic                    lane_end,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int unsigned AW = $clog2(FRAME_WIDTH);
	localparam int unsigned IW = AW + 1;
	localparam int unsigned CXW = (IW > 9) ? IW : 9;
	localparam int unsigned HW = $clog2(FRAME_HEIGHT + 1);
	localparam int unsigned RXW = (HW > 8) ? HW : 8;

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_INC = 3'd2;
	localparam logic [2:0] ST_SCAN_L = 3'd3;
	localparam logic [2:0] ST_SCAN_R = 3'd4;
	localparam logic [2:0] ST_CENTER = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_END = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_CENTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LANE_END_TH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_SMALL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LARGE = 3'd6;

	logic [2:0]             state_q;
	logic [IW-1:0]          idx_q;
	logic                   idx_end;
	logic [AW-1:0]          idx_s1;
	logic                   vld_s1;
	logic [AW-1:0]          col_q;
	logic                   count_q;
	logic                   last_q;
	logic [TOTAL_W-1:0]     total_q;
	steer_code_t            last_code_q;
	logic                   out_valid_q;

	logic [7:0]             roi_top_q;
	logic [WIN_W-1:0]       left_end_q;
	logic [WIN_W-1:0]       right_start_q;
	logic [WIN_W-1:0]       frame_center_q;
	logic [TOTAL_W-1:0]     lane_end_th_q;
	logic [WIN_W-1:0]       band_small_q;
	logic [WIN_W-1:0]       band_large_q;

	logic                   in_xfer;
	logic                   out_xfer;
	logic [CXW-1:0]         col_ext;
	logic                   in_frame;
	logic                   scanning;
	logic [AW-1:0]          rd_addr;
	logic [CNT_W-1:0]       rd_data;
	logic                   mem_we;
	logic [AW-1:0]          wr_addr;
	logic [CNT_W-1:0]       wr_data;
	scan_ctl_t              scan_ctl;
	logic [AW-1:0]          left_pos;
	logic [AW-1:0]          right_pos;
	logic [AW-1:0]          center;
	logic signed [OFF_W-1:0] offset_c;
	steer_code_t            code_c;
	logic                   lane_end_c;
	logic                   result_load;

	// Handshakes.
	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_xfer = out_valid_q && out_ready;

	assign col_ext = CXW'(column);
	assign in_frame = pixel_on && (col_ext < CXW'(FRAME_WIDTH))
	                  && (RXW'(row) < RXW'(FRAME_HEIGHT));
	assign idx_end = (idx_q == IW'(FRAME_WIDTH));
	assign scanning = (state_q == ST_SCAN_L) || (state_q == ST_SCAN_R);
	assign lane_end_c = (total_q > lane_end_th_q);
	assign result_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_top_q <= 8'd140;
			left_end_q <= 9'd150;
			right_start_q <= 9'd250;
			frame_center_q <= 9'd187;
			lane_end_th_q <= 17'd10000;
			band_small_q <= 9'd10;
			band_large_q <= 9'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROI_TOP: begin
					roi_top_q <= cfg_data[7:0];
				end
				REG_LEFT_END: begin
					left_end_q <= cfg_data[WIN_W-1:0];
				end
				REG_RIGHT_START: begin
					right_start_q <= cfg_data[WIN_W-1:0];
				end
				REG_FRAME_CENTER: begin
					frame_center_q <= cfg_data[WIN_W-1:0];
				end
				REG_LANE_END_TH: begin
					lane_end_th_q <= cfg_data[TOTAL_W-1:0];
				end
				REG_BAND_SMALL: begin
					band_small_q <= cfg_data[WIN_W-1:0];
				end
				REG_BAND_LARGE: begin
					band_large_q <= cfg_data[WIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer: clearing pass, pixel update, two scan passes, result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= scanning && !idx_end;
			case (state_q)
				ST_CLEAR: begin
					if (idx_end) begin
						idx_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_INC;
					end
				end
				ST_INC: begin
					if (last_q) begin
						idx_q <= '0;
						state_q <= ST_SCAN_L;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN_L: begin
					if (idx_end) begin
						idx_q <= '0;
						state_q <= ST_SCAN_R;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN_R: begin
					if (idx_end) begin
						idx_q <= '0;
						state_q <= ST_CENTER;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CENTER: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (result_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan pipeline tag: the column whose count is in the read register.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[AW-1:0];
	end

	// Pixel capture for the read-modify-write cycle. The end-of-frame mark is
	// held here because the input may change right after the transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_q <= col_ext[AW-1:0];
			count_q <= in_frame && (row >= roi_top_q);
			last_q <= frame_last;
		end
	end

	// Frame total, saturating; cleared once the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (result_load) begin
			total_q <= '0;
		end else if (in_xfer && in_frame && (total_q != TOTAL_MAX)) begin
			total_q <= total_q + 1'b1;
		end
	end

	// Column memory ports.
	assign rd_addr = (state_q == ST_IDLE) ? col_ext[AW-1:0] : idx_q[AW-1:0];

	always_comb begin
		mem_we = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = '0;
		if (state_q == ST_INC) begin
			mem_we = count_q;
			wr_addr = col_q;
			wr_data = (rd_data == CNT_MAX) ? rd_data : rd_data + 1'b1;
		end else if ((state_q == ST_SCAN_R || state_q == ST_CLEAR) && !idx_end) begin
			mem_we = 1'b1;
		end
	end

	lhs_col_mem #(
		.DEPTH(FRAME_WIDTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.rd_addr(rd_addr),
		.rd_data_q(rd_data),
		.wr_en(mem_we),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Peak search control.
	assign scan_ctl.start = (state_q == ST_INC) && last_q;
	assign scan_ctl.cmp_vld = vld_s1;
	assign scan_ctl.right = (state_q == ST_SCAN_R);
	assign scan_ctl.phase_end = scanning && idx_end;

	lhs_peak_scan #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.AW(AW)
	) u_peak (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(scan_ctl),
		.idx_s1(idx_s1),
		.cnt(rd_data),
		.left_window_end(left_end_q),
		.right_window_start(right_start_q),
		.left_q(left_pos),
		.right_q(right_pos)
	);

	lhs_steer #(
		.AW(AW)
	) u_steer (
		.clk(clk),
		.load(state_q == ST_CENTER),
		.left_pos(left_pos),
		.right_pos(right_pos),
		.frame_center(frame_center_q),
		.band_small(band_small_q),
		.band_large(band_large_q),
		.lane_end(lane_end_c),
		.last_code(last_code_q),
		.center_q(center),
		.offset(offset_c),
		.code(code_c)
	);

	// Output register and the stored steering code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_code_q <= STEER_FWD;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
			last_code_q <= code_c;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			left_position <= POS_OUT_W'(left_pos);
			right_position <= POS_OUT_W'(right_pos);
			lane_center <= POS_OUT_W'(center);
			offset <= offset_c;
			steering_code <= code_c;
			lane_end <= lane_end_c;
		end
	end

	// A new result appears only out of the result state.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result appeared outside the result state");

	// An ordinary pixel is a read-modify-write through the update state and back to idle.
	a_pixel_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !frame_last) |=> (state_q == ST_INC) ##1 (state_q == ST_IDLE))
		else $error("pixel update did not return to idle in two cycles");

	// The memory is never written while pixels are taken.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("column memory written in idle");

	// The scan index never passes the frame width.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IW'(FRAME_WIDTH))
		else $error("scan index out of range");

endmodule
